[rtl/core/ps2mpd_pkg.sv]
// Shared types and constants for the PS/2 mouse packet decoder.
// No dependencies; imported by every module of the decoder.
package ps2mpd_pkg;

    // Kind codes carried in the low bits of each result word
    typedef enum logic [1:0] {
        EV_MOVED    = 2'd0,
        EV_DOUBLE   = 2'd1,
        EV_CLICKED  = 2'd2,
        EV_RELEASED = 2'd3
    } event_kind_t;

    // Header bit positions of the first packet byte
    localparam int unsigned HDR_SYNC_BIT   = 3;
    localparam int unsigned HDR_X_SIGN_BIT = 4;
    localparam int unsigned HDR_Y_SIGN_BIT = 5;
    localparam int unsigned HDR_X_OVF_BIT  = 6;
    localparam int unsigned HDR_Y_OVF_BIT  = 7;

    localparam int unsigned NUM_BUTTONS = 3;

    // Double-click window after reset, in milliseconds
    localparam logic [15:0] WINDOW_RESET = 16'd300;

    // Event set produced by one complete packet
    typedef struct packed {
        logic                   move;
        logic signed [8:0]      move_x;
        logic signed [9:0]      move_y;
        logic [NUM_BUTTONS-1:0] dbl;
        logic [NUM_BUTTONS-1:0] press;
        logic [NUM_BUTTONS-1:0] release_mask;
    } job_t;

    // One result word as carried on the output channel
    typedef struct packed {
        logic [NUM_BUTTONS-1:0] button_mask;
        logic signed [9:0]      move_y;
        logic signed [8:0]      move_x;
        event_kind_t            event_kind;
    } event_t;

endpackage

[rtl/core/ps2mpd_front.sv]
// Front end: accepts mouse bytes, assembles packets and classifies events.
// Depends on ps2mpd_pkg; feeds one job per packet into the job queue.
module ps2mpd_front
    import ps2mpd_pkg::*;
(
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        in_valid,
    input  logic [7:0]  in_byte,
    input  logic [31:0] in_time,
    input  logic        in_accept,
    input  logic        cfg_write,
    input  logic [15:0] cfg_data,
    output logic        job_push,
    output job_t        job
);

    typedef enum logic [2:0] {
        PH_HDR = 3'b001,
        PH_X   = 3'b010,
        PH_Y   = 3'b100
    } phase_t;

    // Where the press time comes from after each press in the scan
    typedef enum logic [1:0] {
        LS_OLD  = 2'd0,
        LS_ZERO = 2'd1,
        LS_TIME = 2'd2
    } lpt_src_t;

    phase_t                 phase_reg, phase_next;
    logic [7:0]             header_reg;
    logic [8:0]             held_x_reg;
    logic [NUM_BUTTONS-1:0] prev_buttons_reg;
    logic [31:0]            last_press_reg, last_press_next;
    logic [15:0]            window_reg;

    logic [8:0]             y9;
    logic signed [9:0]      neg_y;
    logic [NUM_BUTTONS-1:0] press, rel, dbl;
    logic [31:0]            elapsed;
    logic                   hit_old, hit_zero, hit_time, hit;
    lpt_src_t               src;
    logic                   move;

    // Classify the third byte of a packet
    always_comb begin
        y9       = {header_reg[HDR_Y_SIGN_BIT], in_byte};
        neg_y    = 10'sd0 - $signed({y9[8], y9});
        press    = header_reg[NUM_BUTTONS-1:0] & ~prev_buttons_reg;
        rel      = prev_buttons_reg & ~header_reg[NUM_BUTTONS-1:0];
        elapsed  = in_time - last_press_reg;
        hit_old  = elapsed < {16'd0, window_reg};
        // after a double click the remembered time is zero, so the gap is the time itself
        hit_zero = in_time < {16'd0, window_reg};
        // after a plain press the remembered time is now, so the gap is zero
        hit_time = window_reg != 16'd0;
        move     = !header_reg[HDR_X_OVF_BIT] && !header_reg[HDR_Y_OVF_BIT]
                   && (held_x_reg != 9'd0 || y9 != 9'd0);
        // Scan buttons in order; each press resets the remembered time
        src = LS_OLD;
        dbl = '0;
        hit = 1'b0;
        for (int i = 0; i < NUM_BUTTONS; i++) begin
            if (press[i]) begin
                unique case (src)
                    LS_OLD:  hit = hit_old;
                    LS_ZERO: hit = hit_zero;
                    LS_TIME: hit = hit_time;
                    default: hit = hit_old;
                endcase
                dbl[i] = hit;
                src    = hit ? LS_ZERO : LS_TIME;
            end
        end
        unique case (src)
            LS_OLD:  last_press_next = last_press_reg;
            LS_ZERO: last_press_next = 32'd0;
            LS_TIME: last_press_next = in_time;
            default: last_press_next = last_press_reg;
        endcase
    end

    // Advance packet phase
    always_comb begin
        phase_next = phase_reg;
        unique case (phase_reg)
            PH_HDR:  phase_next = in_byte[HDR_SYNC_BIT] ? PH_X : PH_HDR;
            PH_X:    phase_next = PH_Y;
            PH_Y:    phase_next = PH_HDR;
            default: phase_next = PH_HDR;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            phase_reg        <= PH_HDR;
            header_reg       <= '0;
            held_x_reg       <= '0;
            prev_buttons_reg <= '0;
            last_press_reg   <= '0;
            window_reg       <= WINDOW_RESET;
        end else begin
            if (cfg_write) begin
                window_reg <= cfg_data;
            end
            if (in_accept) begin
                phase_reg <= phase_next;
                unique case (phase_reg)
                    PH_X: begin
                        held_x_reg <= {header_reg[HDR_X_SIGN_BIT], in_byte};
                    end
                    PH_Y: begin
                        prev_buttons_reg <= header_reg[NUM_BUTTONS-1:0];
                        last_press_reg   <= last_press_next;
                    end
                    default: begin
                        header_reg <= in_byte;
                    end
                endcase
            end
        end
    end

    // Push a job only when the packet yields at least one event
    assign job_push = in_accept && in_valid && (phase_reg == PH_Y)
                      && (move || press != '0 || rel != '0);

    assign job.move         = move;
    assign job.move_x       = $signed(held_x_reg);
    assign job.move_y       = neg_y;
    assign job.dbl          = dbl;
    assign job.press        = press;
    assign job.release_mask = rel;

endmodule

[rtl/core/ps2mpd_fifo.sv]
// Short job queue between the front end and the event sequencer.
// Depends on ps2mpd_pkg for the job type.
module ps2mpd_fifo
    import ps2mpd_pkg::*;
#(
    parameter int unsigned DEPTH = 2
) (
    input  logic aclk,
    input  logic aresetn,
    input  logic push,
    input  job_t push_job,
    output logic full,
    input  logic pop,
    output logic not_empty,
    output job_t pop_job
);

    localparam int unsigned PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int unsigned CW = $clog2(DEPTH + 1);
    localparam logic [PW-1:0] LAST_PTR = PW'(DEPTH - 1);
    localparam logic [CW-1:0] FULL_CNT = CW'(DEPTH);

    job_t          mem [DEPTH];
    logic [PW-1:0] wr_ptr_reg, rd_ptr_reg;
    logic [CW-1:0] count_reg;
    logic          do_push, do_pop;

    assign full      = count_reg == FULL_CNT;
    assign not_empty = count_reg != '0;
    assign do_push   = push && !full;
    assign do_pop    = pop && not_empty;
    assign pop_job   = mem[rd_ptr_reg];

    // Store pushed words
    always_ff @(posedge aclk) begin
        if (do_push) begin
            mem[wr_ptr_reg] <= push_job;
        end
    end

    // Advance pointers and occupancy
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            if (do_push) begin
                wr_ptr_reg <= (wr_ptr_reg == LAST_PTR) ? '0 : wr_ptr_reg + 1'b1;
            end
            if (do_pop) begin
                rd_ptr_reg <= (rd_ptr_reg == LAST_PTR) ? '0 : rd_ptr_reg + 1'b1;
            end
            if (do_push && !do_pop) begin
                count_reg <= count_reg + 1'b1;
            end else if (do_pop && !do_push) begin
                count_reg <= count_reg - 1'b1;
            end
        end
    end

endmodule

[rtl/core/ps2mpd_back.sv]
// Back end: walks a job's events and emits one word per cycle unless stalled.
// Depends on ps2mpd_pkg; pulls jobs from the job queue.
module ps2mpd_back
    import ps2mpd_pkg::*;
(
    input  logic   aclk,
    input  logic   aresetn,
    input  logic   job_avail,
    input  job_t   job_in,
    output logic   job_pop,
    output logic   out_valid,
    input  logic   out_ready,
    output event_t out_event,
    output logic   out_last
);

    logic                   cur_valid_reg, cur_valid_next;
    job_t                   cur_reg, cur_next;
    logic                   out_valid_reg;
    event_t                 out_event_reg, ev;
    logic                   out_last_reg;
    logic                   out_free, emit, last;
    logic [NUM_BUTTONS-1:0] dbl_pick;

    assign out_free = !out_valid_reg || out_ready;
    assign emit     = cur_valid_reg && out_free;

    // Pick the next event in order: move, double clicks, click, release
    always_comb begin
        cur_next       = cur_reg;
        dbl_pick       = cur_reg.dbl & (~cur_reg.dbl + 1'b1);
        ev.event_kind  = EV_MOVED;
        ev.move_x      = '0;
        ev.move_y      = '0;
        ev.button_mask = '0;
        priority if (cur_reg.move) begin
            ev.move_x     = cur_reg.move_x;
            ev.move_y     = cur_reg.move_y;
            cur_next.move = 1'b0;
        end else if (cur_reg.dbl != '0) begin
            ev.event_kind  = EV_DOUBLE;
            ev.button_mask = dbl_pick;
            cur_next.dbl   = cur_reg.dbl & ~dbl_pick;
        end else if (cur_reg.press != '0) begin
            ev.event_kind  = EV_CLICKED;
            ev.button_mask = cur_reg.press;
            cur_next.press = '0;
        end else begin
            ev.event_kind         = EV_RELEASED;
            ev.button_mask        = cur_reg.release_mask;
            cur_next.release_mask = '0;
        end
        last = !cur_next.move && cur_next.dbl == '0 && cur_next.press == '0
               && cur_next.release_mask == '0;
    end

    // Load a new job when idle or when the current one sends its last word
    assign job_pop = job_avail && (!cur_valid_reg || (emit && last));

    always_comb begin
        cur_valid_next = cur_valid_reg;
        if (job_pop) begin
            cur_valid_next = 1'b1;
        end else if (emit && last) begin
            cur_valid_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (job_pop) begin
            cur_reg <= job_in;
        end else if (emit) begin
            cur_reg <= cur_next;
        end
        if (emit) begin
            out_event_reg <= ev;
            out_last_reg  <= last;
        end
    end

    // Hold the output word until taken
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cur_valid_reg <= 1'b0;
            out_valid_reg <= 1'b0;
        end else begin
            cur_valid_reg <= cur_valid_next;
            if (emit) begin
                out_valid_reg <= 1'b1;
            end else if (out_ready) begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    assign out_valid = out_valid_reg;
    assign out_event = out_event_reg;
    assign out_last  = out_last_reg;

endmodule

[rtl/core/ps2_mouse_packet_decoder.sv]
// PS/2 mouse packet decoder, top level: front end, job queue, event sequencer.
// Depends on ps2mpd_pkg, ps2mpd_front, ps2mpd_fifo and ps2mpd_back.
//
// Takes one mouse byte per word with a millisecond timestamp and assembles
// 3-byte packets; a header byte without its always-one bit is dropped. A
// byte is accepted every cycle while the job queue has room. The first and
// second bytes of a packet produce no output. The third byte is classified
// combinationally on acceptance; its events (move, double clicks, click,
// release; up to five) leave the event sequencer at one word per cycle
// unless m_tready stalls it, the last marked by m_tlast; a packet with no
// events produces no word. The event sequencer sets the output rate.
// The double-click window register is written through cfg_valid/cfg_data;
// the user must do so only while no packet is in flight; not enforced.
module ps2_mouse_packet_decoder
    import ps2mpd_pkg::*;
#(
    parameter int unsigned QUEUE_DEPTH = 2
) (
    input  logic        aclk,
    input  logic        aresetn,
    // data_byte [7:0], time_ms [39:8]
    input  logic [39:0] s_tdata,
    input  logic        s_tvalid,
    output logic        s_tready,
    // event_kind [1:0], move_x [10:2], move_y [20:11], button_mask [23:21]
    output logic [23:0] m_tdata,
    output logic        m_tlast,
    output logic        m_tvalid,
    input  logic        m_tready,
    // double_click_window [15:0]
    input  logic [15:0] cfg_data,
    input  logic        cfg_valid,
    output logic        cfg_ready
);

    logic   q_full, q_avail, q_pop, job_push, in_accept;
    job_t   front_job, back_job;
    event_t ev;

    assign s_tready  = !q_full;
    assign in_accept = s_tvalid && s_tready;
    assign cfg_ready = 1'b1;

    ps2mpd_front u_front (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .in_valid  (s_tvalid),
        .in_byte   (s_tdata[7:0]),
        .in_time   (s_tdata[39:8]),
        .in_accept (in_accept),
        .cfg_write (cfg_valid && cfg_ready),
        .cfg_data  (cfg_data),
        .job_push  (job_push),
        .job       (front_job)
    );

    ps2mpd_fifo #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .push      (job_push),
        .push_job  (front_job),
        .full      (q_full),
        .pop       (q_pop),
        .not_empty (q_avail),
        .pop_job   (back_job)
    );

    ps2mpd_back u_back (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .job_avail (q_avail),
        .job_in    (back_job),
        .job_pop   (q_pop),
        .out_valid (m_tvalid),
        .out_ready (m_tready),
        .out_event (ev),
        .out_last  (m_tlast)
    );

    assign m_tdata = ev;

endmodule

[tb/sv/tb_top.sv]
// Self-checking testbench for the PS/2 mouse packet decoder.
// Depends on ps2mpd_pkg and ps2_mouse_packet_decoder; a scoreboard class predicts
// the event words of every packet and checks them in order against m_tdata/m_tlast.
module tb_top;
    import ps2mpd_pkg::*;

    localparam int unsigned SETTLE_CYCLES   = 16;
    localparam int unsigned ITEMS_PER_PHASE = 55;
    localparam int unsigned NUM_PHASES      = 6;
    localparam int unsigned REPORT_LIMIT    = 10;
    localparam int unsigned IDLE_PERCENT    = 27;

    typedef enum logic [1:0] {
        PH_HEADER,
        PH_X,
        PH_Y
    } packet_phase_t;

    typedef struct {
        event_t word;
        logic   last;
    } pending_event_t;

    // Packet predictor and in-order event checker
    class mouse_event_scoreboard;
        logic [15:0]    window;
        packet_phase_t  phase;
        logic [7:0]     header;
        logic [8:0]     held_x;
        logic [2:0]     prev_buttons;
        logic [31:0]    last_press_ms;
        pending_event_t pending[$];
        int unsigned    mismatches;

        function new();
            window        = WINDOW_RESET;
            phase         = PH_HEADER;
            header        = '0;
            held_x        = '0;
            prev_buttons  = '0;
            last_press_ms = '0;
            mismatches    = 0;
        endfunction

        function void set_window(logic [15:0] w);
            window = w;
        endfunction

        function int unsigned outstanding();
            return pending.size();
        endfunction

        // Advance the packet state by one accepted byte and queue its events
        function void take_byte(logic [7:0] b, logic [31:0] t);
            event_t         run[$];
            event_t         ev;
            pending_event_t pe;
            logic [8:0]     y9;
            logic [9:0]     neg_y;
            logic [2:0]     press_mask;
            logic [2:0]     rel_mask;
            logic [31:0]    since;
            int             i;
            case (phase)
                PH_X: begin
                    held_x = {header[HDR_X_SIGN_BIT], b};
                    phase  = PH_Y;
                end
                PH_Y: begin
                    y9         = {header[HDR_Y_SIGN_BIT], b};
                    neg_y      = 10'd0 - {y9[8], y9};
                    press_mask = '0;
                    rel_mask   = '0;
                    // move word only without overflow and with some motion
                    if (!header[HDR_X_OVF_BIT] && !header[HDR_Y_OVF_BIT] &&
                        (held_x != 0 || neg_y != 0)) begin
                        ev.event_kind  = EV_MOVED;
                        ev.move_x      = held_x;
                        ev.move_y      = neg_y;
                        ev.button_mask = '0;
                        run.push_back(ev);
                    end
                    // scan buttons left, right, middle
                    for (i = 0; i < NUM_BUTTONS; i++) begin
                        if (header[i] && !prev_buttons[i]) begin
                            press_mask[i] = 1'b1;
                            since = t - last_press_ms;
                            if (since < {16'd0, window}) begin
                                ev.event_kind  = EV_DOUBLE;
                                ev.move_x      = '0;
                                ev.move_y      = '0;
                                ev.button_mask = 3'(1 << i);
                                run.push_back(ev);
                                last_press_ms = '0;
                            end else begin
                                last_press_ms = t;
                            end
                        end else if (!header[i] && prev_buttons[i]) begin
                            rel_mask[i] = 1'b1;
                        end
                    end
                    ev.move_x = '0;
                    ev.move_y = '0;
                    if (press_mask != 0) begin
                        ev.event_kind  = EV_CLICKED;
                        ev.button_mask = press_mask;
                        run.push_back(ev);
                    end
                    if (rel_mask != 0) begin
                        ev.event_kind  = EV_RELEASED;
                        ev.button_mask = rel_mask;
                        run.push_back(ev);
                    end
                    prev_buttons = header[2:0];
                    phase        = PH_HEADER;
                    for (i = 0; i < run.size(); i++) begin
                        pe.word = run[i];
                        pe.last = (i == run.size() - 1);
                        pending.push_back(pe);
                    end
                end
                default: begin
                    // drop a header without its sync bit, but keep the byte
                    header = b;
                    phase  = b[HDR_SYNC_BIT] ? PH_X : PH_HEADER;
                end
            endcase
        endfunction

        // Compare one output word with the oldest expected event
        function void check_event(event_t got, logic got_last);
            pending_event_t want;
            if (pending.size() == 0) begin
                mismatches++;
                if (mismatches <= REPORT_LIMIT)
                    $display("unexpected event word %h last %b", got, got_last);
                return;
            end
            want = pending.pop_front();
            if (got.event_kind !== want.word.event_kind || got.move_x !== want.word.move_x ||
                got.move_y !== want.word.move_y ||
                got.button_mask !== want.word.button_mask || got_last !== want.last) begin
                mismatches++;
                if (mismatches <= REPORT_LIMIT)
                    $display("event mismatch: expected kind %0d x %0d y %0d mask %b last %b, got kind %0d x %0d y %0d mask %b last %b",
                             want.word.event_kind, want.word.move_x, want.word.move_y,
                             want.word.button_mask, want.last, got.event_kind, got.move_x,
                             got.move_y, got.button_mask, got_last);
            end
        endfunction
    endclass

    logic        aclk      = 1'b0;
    logic        aresetn   = 1'b0;
    logic [39:0] s_tdata   = '0;
    logic        s_tvalid  = 1'b0;
    logic        s_tready;
    logic [23:0] m_tdata;
    logic        m_tlast;
    logic        m_tvalid;
    logic        m_tready  = 1'b0;
    logic [15:0] cfg_data  = '0;
    logic        cfg_valid = 1'b0;
    logic        cfg_ready;

    logic        steady = 1'b0;
    logic [31:0] now_ms = '0;

    mouse_event_scoreboard sb = new();

    ps2_mouse_packet_decoder i_dut (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_tdata   (s_tdata),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .m_tdata   (m_tdata),
        .m_tlast   (m_tlast),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .cfg_data  (cfg_data),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready)
    );

    initial begin
        forever #1 aclk = ~aclk;
    end

    // Stall the event side at random, except in the steady stretch
    always @(posedge aclk) begin
        if (!aresetn || steady)
            m_tready <= 1'b1;
        else
            m_tready <= ($urandom_range(0, 99) >= IDLE_PERCENT);
    end

    // Check every event word taken by the receiver
    always @(posedge aclk) begin
        if (aresetn && m_tvalid && m_tready)
            sb.check_event(event_t'(m_tdata), m_tlast);
    end

    initial begin
        #200000;
        $display("Test completed with failures");
        $finish;
    end

    // Advance the millisecond clock, with jumps and wraps past zero
    function automatic logic [31:0] next_ms();
        int unsigned r;
        r = $urandom_range(0, 11);
        if (r == 0)
            now_ms = $urandom();
        else if (r == 1)
            now_ms = 32'hFFFF_FFFF - $urandom_range(0, 400);
        else
            now_ms = now_ms + $urandom_range(0, 150);
        return now_ms;
    endfunction

    // Hold off the sender for a random number of cycles
    task automatic sender_pause();
        while (!steady && $urandom_range(0, 99) < IDLE_PERCENT) begin
            s_tvalid <= 1'b0;
            @(posedge aclk);
        end
    endtask

    task automatic send_byte(input logic [7:0] b, input logic [31:0] t);
        sender_pause();
        s_tdata  <= {t, b};
        s_tvalid <= 1'b1;
        @(posedge aclk);
        while (!s_tready) @(posedge aclk);
        sb.take_byte(b, t);
    endtask

    task automatic send_packet(input logic [7:0] hdr, input logic [7:0] x,
                               input logic [7:0] y, input logic [31:0] t);
        send_byte(hdr, t);
        send_byte(x, t);
        send_byte(y, t);
    endtask

    // Well-formed packet with random buttons, signs and motion
    task automatic send_random_packet();
        logic [7:0] hdr;
        logic [7:0] x;
        logic [7:0] y;
        hdr                 = 8'($urandom());
        hdr[HDR_SYNC_BIT]   = 1'b1;
        hdr[HDR_X_OVF_BIT]  = ($urandom_range(0, 7) == 0);
        hdr[HDR_Y_OVF_BIT]  = ($urandom_range(0, 7) == 0);
        x = ($urandom_range(0, 5) == 0) ? 8'h00 : 8'($urandom());
        y = ($urandom_range(0, 5) == 0) ? 8'h00 : 8'($urandom());
        send_byte(hdr, next_ms());
        send_byte(x, next_ms());
        send_byte(y, next_ms());
    endtask

    // Close any open packet, then wait until every expected word is out
    task automatic drain_packets();
        while (sb.phase != PH_HEADER) send_byte(8'($urandom()), next_ms());
        s_tvalid <= 1'b0;
        @(posedge aclk);
        while (sb.outstanding() != 0) @(posedge aclk);
        repeat (SETTLE_CYCLES) @(posedge aclk);
    endtask

    task automatic write_window(input logic [15:0] w);
        cfg_data  <= w;
        cfg_valid <= 1'b1;
        @(posedge aclk);
        while (!cfg_ready) @(posedge aclk);
        sb.set_window(w);
        cfg_valid <= 1'b0;
    endtask

    initial begin
        int unsigned ph;
        int unsigned count;
        int unsigned r;
        logic [7:0]  b;

        repeat (10) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // Directed packets under the reset window
        send_byte(8'h00, 32'd0);                // header without sync bit: dropped
        send_byte(8'hF7, 32'hFFFF_FFFF);        // every bit but sync: dropped
        send_packet(8'h08, 8'h00, 8'h00, 32'd10);   // no motion, no buttons: no word
        send_packet(8'h09, 8'h7F, 8'h80, 32'd1000); // left press, move
        send_packet(8'h39, 8'h00, 8'h00, 32'd1100); // both signs, zero bytes
        send_packet(8'hF8, 8'hFF, 8'hFF, 32'd1200); // overflow hides move; left release
        send_packet(8'h09, 8'h01, 8'h00, 32'd1300); // press exactly one window later
        send_packet(8'h0F, 8'h80, 8'hFF, 32'd1599); // right double click, middle press
        send_packet(8'h08, 8'h00, 8'h00, 32'd1700); // release all three
        now_ms = 32'hFFFF_F000;

        // Random phases, each under its own window
        for (ph = 0; ph < NUM_PHASES; ph++) begin
            if (ph != 0) begin
                drain_packets();
                case (ph)
                    1:       write_window(16'd0);
                    2:       write_window(16'hFFFF);
                    3:       write_window(16'd1);
                    4:       write_window(16'($urandom_range(2, 65534)));
                    default: write_window(WINDOW_RESET);
                endcase
            end
            steady = (ph == 2);
            count  = 0;
            while (count < ITEMS_PER_PHASE) begin
                r = $urandom_range(0, 99);
                if (r < 80) begin
                    send_random_packet();
                    count += 3;
                end else if (r < 90) begin
                    b = 8'($urandom());
                    send_byte(b, next_ms());
                    if (b[HDR_SYNC_BIT] || sb.phase != PH_X)
                        count++;
                end else begin
                    // broken packet: header and one byte only
                    send_byte(8'($urandom()) | 8'h08, next_ms());
                    send_byte(8'($urandom()), next_ms());
                    count += 2;
                end
            end
        end
        steady = 1'b0;

        drain_packets();
        if (sb.mismatches == 0 && sb.outstanding() == 0)
            $display("Test completed successfully");
        else
            $display("Test completed with failures");
        $finish;
    end

endmodule
